FILE: hdl/mck_pkg.sv
// Shared types, constants and code tables for the Morse keyer.
// No dependencies; every other file imports this package.
package mck_pkg;

   localparam int CHAR_W   = 8;
   localparam int UNIT_W   = 24;
   localparam int DRIVE_W  = 8;
   localparam int DUR_W    = 26;
   localparam int LEN_W    = 3;
   localparam int DASH_W   = 4;
   localparam int POS_W    = 4;
   localparam int LETTER_W = 5;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = UNIT_W;

   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_TICKS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ON_DRIVE   = 1'd1;

   localparam logic [UNIT_W-1:0]  UNIT_TICKS_RST = 24'd200000;
   localparam logic [DRIVE_W-1:0] ON_DRIVE_RST   = 8'd3;

   localparam logic [CHAR_W-1:0] CHAR_A = 8'd65;
   localparam logic [CHAR_W-1:0] CHAR_Z = 8'd90;

   localparam logic [DRIVE_W-1:0] DRIVE_OFF = '0;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [UNIT_W-1:0]  unit_ticks;
      logic [DRIVE_W-1:0] on_drive;
   } mck_cfg_type;

   // One classified character, as handed from front to back.
   typedef struct packed {
      logic              first;
      logic              last;
      logic [LEN_W-1:0]  len;
      logic [DASH_W-1:0] dash;
   } mck_desc_type;

   // Number of elements of letters A..Z.
   function automatic logic [LEN_W-1:0] letter_len(input logic [LETTER_W-1:0] idx);
      logic [LEN_W-1:0] res;
      unique case (idx)
         5'd0:  res = 3'd2;  5'd1:  res = 3'd4;  5'd2:  res = 3'd4;
         5'd3:  res = 3'd3;  5'd4:  res = 3'd1;  5'd5:  res = 3'd4;
         5'd6:  res = 3'd3;  5'd7:  res = 3'd4;  5'd8:  res = 3'd2;
         5'd9:  res = 3'd4;  5'd10: res = 3'd3;  5'd11: res = 3'd4;
         5'd12: res = 3'd2;  5'd13: res = 3'd2;  5'd14: res = 3'd3;
         5'd15: res = 3'd4;  5'd16: res = 3'd4;  5'd17: res = 3'd3;
         5'd18: res = 3'd3;  5'd19: res = 3'd1;  5'd20: res = 3'd3;
         5'd21: res = 3'd4;  5'd22: res = 3'd3;  5'd23: res = 3'd4;
         5'd24: res = 3'd4;  5'd25: res = 3'd4;
         default: res = '0;
      endcase
      return res;
   endfunction

   // Bit i set: element i is a dash.
   function automatic logic [DASH_W-1:0] letter_dash(input logic [LETTER_W-1:0] idx);
      logic [DASH_W-1:0] res;
      unique case (idx)
         5'd0:  res = 4'd2;  5'd1:  res = 4'd1;  5'd2:  res = 4'd5;
         5'd3:  res = 4'd1;  5'd4:  res = 4'd0;  5'd5:  res = 4'd4;
         5'd6:  res = 4'd3;  5'd7:  res = 4'd0;  5'd8:  res = 4'd0;
         5'd9:  res = 4'd14; 5'd10: res = 4'd5;  5'd11: res = 4'd2;
         5'd12: res = 4'd3;  5'd13: res = 4'd1;  5'd14: res = 4'd7;
         5'd15: res = 4'd6;  5'd16: res = 4'd11; 5'd17: res = 4'd2;
         5'd18: res = 4'd0;  5'd19: res = 4'd1;  5'd20: res = 4'd4;
         5'd21: res = 4'd8;  5'd22: res = 4'd6;  5'd23: res = 4'd9;
         5'd24: res = 4'd13; 5'd25: res = 4'd3;
         default: res = '0;
      endcase
      return res;
   endfunction

endpackage

FILE: hdl/mck_channels.sv
// Valid/ready channel interfaces for the keyer's character and segment streams.
// Depends on mck_pkg.
interface mck_req_if;
   import mck_pkg::*;
   logic                valid;
   logic                ready;
   logic [CHAR_W-1:0]   char_code;
   logic                first_of_text;
   logic                last_of_text;

   modport source (output valid, char_code, first_of_text, last_of_text, input ready);
   modport sink   (input valid, char_code, first_of_text, last_of_text, output ready);
endinterface

interface mck_rsp_if;
   import mck_pkg::*;
   logic                valid;
   logic                ready;
   logic [DRIVE_W-1:0]  drive_value;
   logic [DUR_W-1:0]    duration_ticks;
   logic                last_segment;

   modport source (output valid, drive_value, duration_ticks, last_segment, input ready);
   modport sink   (input valid, drive_value, duration_ticks, last_segment, output ready);
endinterface

FILE: hdl/mck_front.sv
// Front end: accepts characters and classifies them into code descriptors.
// Depends on mck_pkg and mck_channels.
module mck_front (
   input  logic                  clock,
   input  logic                  reset,
   mck_req_if.sink               req_chan,
   output logic                  push_valid,
   input  logic                  push_ready,
   output mck_pkg::mck_desc_type push_desc
);
   import mck_pkg::*;

   logic                 valid_ff, valid_in;
   mck_desc_type         desc_ff, desc_in;
   logic                 is_letter;
   logic [CHAR_W-1:0]    offset;
   logic                 accept;

   assign req_chan.ready = !valid_ff || push_ready;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      is_letter = (req_chan.char_code >= CHAR_A) && (req_chan.char_code <= CHAR_Z);
      offset    = req_chan.char_code - CHAR_A;
      desc_in.first = req_chan.first_of_text;
      desc_in.last  = req_chan.last_of_text;
      desc_in.len   = is_letter ? letter_len(offset[LETTER_W-1:0]) : '0;
      desc_in.dash  = is_letter ? letter_dash(offset[LETTER_W-1:0]) : '0;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         desc_ff <= desc_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_desc  = desc_ff;

endmodule

FILE: hdl/mck_queue.sv
// Short descriptor queue decoupling the classifier from the segment sequencer.
// Depends on mck_pkg.
module mck_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  mck_pkg::mck_desc_type push_desc,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output mck_pkg::mck_desc_type pop_desc
);
   import mck_pkg::*;

   mck_desc_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push, pop;

   assign push_ready = count_ff < QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_desc   = mem_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count exceeds depth");
`endif

endmodule

FILE: hdl/mck_back.sv
// Back end: walks each descriptor and emits one timed segment per cycle while rsp_chan is ready.
// Depends on mck_pkg and mck_channels.
module mck_back (
   input  logic                  clock,
   input  logic                  reset,
   input  mck_pkg::mck_cfg_type  cfg,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  mck_pkg::mck_desc_type pop_desc,
   mck_rsp_if.source             rsp_chan
);
   import mck_pkg::*;

   // Position walk: 0 lead gap, 1 char gap, even 2..2len marks, odd gaps,
   // 2len+2 trailing gap.
   logic               busy_ff, busy_in;
   mck_desc_type       desc_ff, desc_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DRIVE_W-1:0] drive_ff, drive_in;
   logic [DUR_W-1:0]   dur_ff, dur_in;
   logic               last_ff, last_in;

   logic [POS_W-1:0]   end_pos, mark_top;
   logic [LEN_W-1:0]   elem;
   logic               is_mark, is_dash, at_end, load_out, emit, take;
   logic [DUR_W-1:0]   unit1, unit3;

   always_comb begin
      unit1    = DUR_W'(cfg.unit_ticks);
      unit3    = unit1 + {unit1[DUR_W-2:0], 1'b0};
      mark_top = {desc_ff.len, 1'b0};
      end_pos  = mark_top + POS_W'(1) + POS_W'(desc_ff.last);
      at_end   = pos_ff == end_pos;
      is_mark  = (pos_ff >= POS_W'(2)) && !pos_ff[0] && (pos_ff <= mark_top);
      elem     = pos_ff[LEN_W:1] - LEN_W'(1);
      is_dash  = desc_ff.dash[elem[1:0]];

      load_out = !rsp_valid_ff || rsp_chan.ready;
      emit     = busy_ff && load_out;
      take     = pop_valid && (!busy_ff || (emit && at_end));

      busy_in = busy_ff;
      desc_in = desc_ff;
      pos_in  = pos_ff;
      if (take) begin
         busy_in = 1'b1;
         desc_in = pop_desc;
         pos_in  = pop_desc.first ? POS_W'(0) : POS_W'(1);
      end else if (emit) begin
         busy_in = !at_end;
         pos_in  = pos_ff + POS_W'(1);
      end

      rsp_valid_in = load_out ? emit : rsp_valid_ff;
      drive_in     = is_mark ? cfg.on_drive : DRIVE_OFF;
      dur_in       = (is_mark && is_dash) ? unit3 : unit1;
      last_in      = at_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      desc_ff <= desc_in;
      if (emit) begin
         drive_ff <= drive_in;
         dur_ff   <= dur_in;
         last_ff  <= last_in;
      end
   end

   assign pop_ready               = !busy_ff || (emit && at_end);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.drive_value    = drive_ff;
   assign rsp_chan.duration_ticks = dur_ff;
   assign rsp_chan.last_segment   = last_ff;

`ifndef NO_ASSERTIONS
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pos_ff <= end_pos)
      else $error("segment position ran past end of item");
   a_mark_not_last: assert property (@(posedge clock) disable iff (reset)
      emit && is_mark |=> !rsp_chan.last_segment)
      else $error("mark segment flagged as last");
`endif

endmodule

FILE: hdl/morse_code_keyer.sv
// Morse keyer top level: config registers, front classifier, queue, sequencer.
// Depends on mck_pkg, mck_channels, mck_front, mck_queue, mck_back.
//
// Usage:
//   req_chan carries one ASCII character per item with first/last-of-text
//   flags. rsp_chan returns timed drive segments (level, length in ticks,
//   last-segment flag); each character gives 1 to 11 segments, the final
//   one marked by last_segment.
//   csr_we/csr_index/csr_wdata write unit_ticks (index 0) and
//   on_drive_value (index 1); write only while no item is in flight.
//   The first segment of an item passes the front register, a queue entry,
//   the sequencer state and the output register before it is valid.
//   Throughput: one segment per cycle from the sequencer while rsp_chan
//   is ready; a two-entry descriptor queue lets new characters be taken
//   while an item is being walked.
//   Reset restores unit_ticks to 200000 and on_drive_value to 3 and empties
//   all stages. When rsp_chan stalls, the held segment stays put and the
//   queue and front stage fill before req_chan.ready drops.
module morse_code_keyer (
   input  logic                              clock,
   input  logic                              reset,
   mck_req_if.sink                           req_chan,
   mck_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [mck_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mck_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import mck_pkg::*;

   logic [UNIT_W-1:0]  unit_ticks_ff, unit_ticks_in;
   logic [DRIVE_W-1:0] on_drive_ff, on_drive_in;
   mck_cfg_type        cfg;

   logic               push_valid, push_ready, pop_valid, pop_ready;
   mck_desc_type       push_desc, pop_desc;

   always_comb begin
      unit_ticks_in = unit_ticks_ff;
      on_drive_in   = on_drive_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_UNIT_TICKS: unit_ticks_in = csr_wdata[UNIT_W-1:0];
            CSR_ON_DRIVE:   on_drive_in   = csr_wdata[DRIVE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff <= UNIT_TICKS_RST;
         on_drive_ff   <= ON_DRIVE_RST;
      end else begin
         unit_ticks_ff <= unit_ticks_in;
         on_drive_ff   <= on_drive_in;
      end
   end

   assign cfg.unit_ticks = unit_ticks_ff;
   assign cfg.on_drive   = on_drive_ff;

   mck_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc)
   );

   mck_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_desc   (pop_desc)
   );

   mck_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_desc  (pop_desc),
      .rsp_chan  (rsp_chan)
   );

endmodule

FILE: verif/morse_code_keyer_test.sv
// Self-checking testbench for morse_code_keyer: drives characters, predicts the
// keyed segments per character and compares them in order at the output.
// Depends on mck_pkg, mck_channels and the keyer RTL.
module morse_code_keyer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import mck_pkg::*;

   localparam int PERIOD = 4;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              first;
      logic              last;
   } char_item_type;

   typedef struct packed {
      logic [DRIVE_W-1:0] level;
      logic [DUR_W-1:0]   ticks;
      logic               tail;
   } segment_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   mck_req_if req_chan ();
   mck_rsp_if rsp_chan ();

   morse_code_keyer dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // dots and dashes of A..Z, first element leftmost
   string morse_tab [26] = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                             ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
                             "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."};

   char_item_type      char_backlog [$];
   segment_type        keyed_segments [$];
   logic [UNIT_W-1:0]  unit_len = UNIT_TICKS_RST;
   logic [DRIVE_W-1:0] mark_level = ON_DRIVE_RST;
   int                 errors = 0;
   int                 req_gap = 0;
   int                 rsp_gap = 0;
   bit                 calm = 1'b0;
   logic               req_fire = 1'b0;

   always #(PERIOD / 2) clock = ~clock;

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic void key_character(char_item_type c);
      logic [DUR_W-1:0] one, three;
      string            code;
      segment_type      segs [$];
      int               e;
      one = DUR_W'(unit_len);
      three = one + (one << 1);
      if (c.first)
         segs.push_back('{DRIVE_OFF, one, 1'b0});
      segs.push_back('{DRIVE_OFF, one, 1'b0});
      if (c.code >= CHAR_A && c.code <= CHAR_Z) begin
         code = morse_tab[c.code - CHAR_A];
         for (e = 0; e < code.len(); e++) begin
            segs.push_back('{mark_level, (code[e] == "-") ? three : one, 1'b0});
            segs.push_back('{DRIVE_OFF, one, 1'b0});
         end
      end
      if (c.last)
         segs.push_back('{DRIVE_OFF, one, 1'b0});
      for (e = 0; e < segs.size(); e++) begin
         segs[e].tail = (e == segs.size() - 1);
         keyed_segments.push_back(segs[e]);
      end
   endfunction

   // character driver
   always @(negedge clock) begin
      char_item_type nxt;
      if (!reset && (!req_chan.valid || req_fire)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_chan.valid <= 1'b0;
         end else if (char_backlog.size() == 0) begin
            req_chan.valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            req_gap = $urandom_range(0, 5);
            req_chan.valid <= 1'b0;
         end else begin
            nxt = char_backlog.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.char_code <= nxt.code;
            req_chan.first_of_text <= nxt.first;
            req_chan.last_of_text <= nxt.last;
         end
      end
   end

   // segment backpressure
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_chan.ready <= !reset;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_chan.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_gap = $urandom_range(0, 5);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // prediction on accepted characters, checking of accepted segments
   always @(posedge clock) begin
      segment_type want;
      req_fire <= !reset && req_chan.valid && req_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready)
         key_character('{req_chan.char_code, req_chan.first_of_text, req_chan.last_of_text});
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (keyed_segments.size() == 0) begin
            errors++;
            $display("%0t: segment with none expected: level %0h ticks %0d last %0b", $time,
                     rsp_chan.drive_value, rsp_chan.duration_ticks, rsp_chan.last_segment);
         end else begin
            want = keyed_segments.pop_front();
            if (rsp_chan.drive_value !== want.level) begin
               errors++;
               $display("%0t: drive_value expected %0h got %0h", $time, want.level,
                        rsp_chan.drive_value);
            end
            if (rsp_chan.duration_ticks !== want.ticks) begin
               errors++;
               $display("%0t: duration_ticks expected %0d got %0d", $time, want.ticks,
                        rsp_chan.duration_ticks);
            end
            if (rsp_chan.last_segment !== want.tail) begin
               errors++;
               $display("%0t: last_segment expected %0b got %0b", $time, want.tail,
                        rsp_chan.last_segment);
            end
         end
      end
   end

   function automatic bit keyer_idle();
      return char_backlog.size() == 0 && !req_chan.valid && keyed_segments.size() == 0;
   endfunction

   task automatic wait_idle(int limit);
      int n;
      n = 0;
      while (!keyer_idle() && n < limit) begin
         @(negedge clock);
         n++;
      end
      repeat (6) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_UNIT_TICKS)
         unit_len = data;
      else
         mark_level = data[DRIVE_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic add_char(logic [CHAR_W-1:0] code, logic first, logic last);
      char_backlog.push_back('{code, first, last});
   endtask

   initial begin
      int               p, i, n, count;
      bit               tidy;
      logic [CHAR_W-1:0] ch;
      req_chan.valid = 1'b0;
      req_chan.char_code = '0;
      req_chan.first_of_text = 1'b0;
      req_chan.last_of_text = 1'b0;
      rsp_chan.ready = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings, table corners, non-letters, flag combinations
      add_char("A", 1'b1, 1'b0);
      add_char("Z", 1'b0, 1'b0);
      add_char("E", 1'b0, 1'b0);
      add_char("T", 1'b0, 1'b1);
      add_char("Q", 1'b1, 1'b1);   // longest: eleven segments
      add_char("J", 1'b0, 1'b0);
      add_char("Y", 1'b1, 1'b0);
      add_char("O", 1'b0, 1'b0);
      add_char("H", 1'b0, 1'b1);
      add_char(8'd0, 1'b0, 1'b0);   // non-letter alone: a single gap
      add_char(8'd255, 1'b1, 1'b1);
      add_char("a", 1'b0, 1'b0);
      add_char("z", 1'b1, 1'b0);
      add_char("@", 1'b0, 1'b1);
      add_char("[", 1'b0, 1'b0);
      add_char(" ", 1'b1, 1'b1);
      add_char("S", 1'b0, 1'b0);
      add_char("M", 1'b1, 1'b1);
      add_char(8'h7f, 1'b0, 1'b0);
      add_char(8'h80, 1'b0, 1'b1);
      wait_idle(20000);

      for (p = 1; p <= 5; p++) begin
         case (p)
            1: begin
               write_reg(CSR_UNIT_TICKS, 24'd1);
               write_reg(CSR_ON_DRIVE, 24'hFFFF_FF);
            end
            2: begin
               write_reg(CSR_UNIT_TICKS, 24'hFF_FFFF);
               write_reg(CSR_ON_DRIVE, 24'h0);
            end
            3: begin
               write_reg(CSR_UNIT_TICKS, 24'd0);   // zero unit: zero-length segments
               write_reg(CSR_ON_DRIVE, CSR_DATA_W'($urandom));
            end
            4: begin
               write_reg(CSR_UNIT_TICKS, CSR_DATA_W'($urandom_range(1, 4000)));
               write_reg(CSR_ON_DRIVE, CSR_DATA_W'($urandom));
            end
            default: begin
               write_reg(CSR_UNIT_TICKS, CSR_DATA_W'($urandom));
               write_reg(CSR_ON_DRIVE, CSR_DATA_W'($urandom));
               calm = 1'b1;
            end
         endcase
         count = 0;
         while (count < 55) begin
            // mostly proper texts; some with random flags
            n = $urandom_range(1, 8);
            tidy = $urandom_range(0, 4) != 0;
            for (i = 0; i < n; i++) begin
               if ($urandom_range(0, 9) < 7)
                  ch = CHAR_W'($urandom_range(CHAR_A, CHAR_Z));
               else
                  ch = CHAR_W'($urandom_range(0, 255));
               if (tidy)
                  add_char(ch, i == 0, i == n - 1);
               else
                  add_char(ch, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            count += n;
         end
         wait_idle(50000);
      end

      if (keyed_segments.size() != 0) begin
         errors++;
         $display("%0t: %0d segments expected, none arrived; next expected ticks %0d got none",
                  $time, keyed_segments.size(), keyed_segments[0].ticks);
      end
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: files.f
hdl/mck_pkg.sv
hdl/mck_channels.sv
hdl/mck_front.sv
hdl/mck_queue.sv
hdl/mck_back.sv
hdl/morse_code_keyer.sv
verif/morse_code_keyer_test.sv
